/* hdl/mtg_pkg.sv */
package mtg_pkg;

  localparam int INSTANCES     = 4;
  localparam int STATE_WORDS   = 624;
  localparam int MAX_KEY_WORDS = 16;
  localparam int SHIFT_M       = 397;

  localparam int ADDR_W     = $clog2(INSTANCES * STATE_WORDS);
  localparam int IDX_W      = 10;
  localparam int INST_W     = 2;
  localparam int KEY_IDX_W  = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KEY_CNT_W  = $clog2(MAX_KEY_WORDS + 1);
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_KEY  = 2'd1;
  localparam logic [1:0] OP_GEN  = 2'd2;

  localparam logic [31:0] TWIST_A      = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] KEY_MULT1    = 32'd1664525;
  localparam logic [31:0] KEY_MULT2    = 32'd1566083941;
  localparam logic [31:0] KEY_SEED     = 32'd19650218;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] HI_BIT       = 32'h80000000;
  localparam logic [31:0] LO_BITS      = 32'h7fffffff;

  localparam logic [IDX_W-1:0] IDX_SPENT    = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);
  localparam logic [IDX_W-1:0] LAST_WORD    = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_SPLIT    = IDX_W'(STATE_WORDS - SHIFT_M);

  typedef struct packed {
    logic [1:0]        opcode;
    logic [INST_W-1:0] inst;
    logic [31:0]       value;
    logic              key_last;
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] twist_one(input logic [31:0] cur, input logic [31:0] nxt,
                                            input logic [31:0] far);
    logic [31:0] y;
    y = (cur & HI_BIT) | (nxt & LO_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_A : 32'd0);
  endfunction

  function automatic logic [ADDR_W-1:0] word_addr(input logic [INST_W-1:0] inst,
                                                  input logic [IDX_W-1:0] off);
    return ADDR_W'(int'(inst) * STATE_WORDS + int'(off));
  endfunction

endpackage

/* hdl/mt19937_multi_instance_generator.sv */
// Bank of independent MT19937 generators sharing one state memory.
// Input channel: the producer drives in_opcode, in_instance_req, in_value and
// in_key_last and raises in_push; the transaction is taken on a clock edge
// where in_push is high and in_full is low. Transactions that address a
// missing instance or carry the unused opcode are taken and dropped.
// Result channel: out_random_word holds the oldest result while out_empty is
// low; out_pop takes it. Only generate transactions produce a result.
// A four-entry command queue separates acceptance from execution, so the
// producer keeps pushing, until the queue is full, while the engine works.
// Execution is sequential on one single-write, dual-read state memory: a
// generate with words left reads its next word and tempers it; one that
// must twist first runs a twist pass over every state word; an unseeded
// instance adds a seeding pass first. A seed runs one seeding pass, and the
// final key word runs seeding, then two mixing passes plus wrap writes.
// Reset (rst_n low at a clock edge) empties both queues, clears the key
// count and marks every instance unseeded; the state memory is not cleared.
// When the consumer stalls, up to two results wait in the output queue and
// the engine holds on the next generate until a slot frees.
module mt19937_multi_instance_generator
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_instance_req,
  input  logic [31:0] in_value,
  input  logic        in_key_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_random_word
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  // Front end: filters and packs each incoming transaction.
  mtg_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_instance_req (in_instance_req),
    .in_value        (in_value),
    .in_key_last     (in_key_last),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // Command queue between the front end and the engine.
  mtg_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Engine: seeding, key mixing, twisting and tempering on the state memory.
  mtg_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (q_empty),
    .cmd             (q_head),
    .cmd_pop         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_random_word (out_random_word)
  );

endmodule

/* hdl/mtg_ram.sv */
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2496
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ra_en,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic                     rb_en,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ra_en) begin
      ra_data <= mem[ra_addr];
    end
    if (rb_en) begin
      rb_data <= mem[rb_addr];
    end
  end

endmodule

/* hdl/mtg_front.sv */
module mtg_front
  import mtg_pkg::*;
(
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_instance_req,
  input  logic [31:0] in_value,
  input  logic        in_key_last,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic useful;

  // Items for a missing instance or with the unused opcode are taken and dropped.
  always_comb begin
    useful = (int'(in_instance_req) < INSTANCES) &&
             ((in_opcode == OP_SEED) || (in_opcode == OP_KEY) || (in_opcode == OP_GEN));
    in_full = q_full;
    q_push  = in_push && !q_full && useful;
    q_cmd.opcode   = in_opcode;
    q_cmd.inst     = INST_W'(in_instance_req);
    q_cmd.value    = in_value;
    q_cmd.key_last = in_key_last;
  end

endmodule

/* hdl/mtg_cmdq.sv */
module mtg_cmdq
  import mtg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wp_r, rp_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

/* hdl/mtg_core.sv */
module mtg_core
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_empty,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_random_word
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEED_MUL = 4'd1;
  localparam logic [3:0] ST_SEED_WR  = 4'd2;
  localparam logic [3:0] ST_K1_RD    = 4'd3;
  localparam logic [3:0] ST_K1_WR    = 4'd4;
  localparam logic [3:0] ST_K1_WRAP  = 4'd5;
  localparam logic [3:0] ST_K2_RD    = 4'd6;
  localparam logic [3:0] ST_K2_WR    = 4'd7;
  localparam logic [3:0] ST_K2_WRAP  = 4'd8;
  localparam logic [3:0] ST_K_FIN    = 4'd9;
  localparam logic [3:0] ST_TW_RD0   = 4'd10;
  localparam logic [3:0] ST_TW_LD    = 4'd11;
  localparam logic [3:0] ST_TW_RD    = 4'd12;
  localparam logic [3:0] ST_TW_WR    = 4'd13;
  localparam logic [3:0] ST_GEN_RD   = 4'd14;
  localparam logic [3:0] ST_GEN_OUT  = 4'd15;

  localparam logic [1:0] MODE_SEED = 2'd0;
  localparam logic [1:0] MODE_KEY  = 2'd1;
  localparam logic [1:0] MODE_GEN  = 2'd2;

  localparam logic [IDX_W-1:0] KEY_ROUNDS1 = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] KEY_ROUNDS2 = IDX_W'(STATE_WORDS - 1);

  logic [3:0]           state_r, state_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [INST_W-1:0]    inst_r, inst_nxt;
  logic [IDX_W-1:0]     n_r, n_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [KEY_IDX_W-1:0] j_r, j_nxt;
  logic [KEY_CNT_W-1:0] len_r, len_nxt;
  logic [KEY_CNT_W-1:0] kcnt_r, kcnt_nxt;
  logic [IDX_W-1:0]     idx_r [INSTANCES];
  logic [IDX_W-1:0]     idx_nxt [INSTANCES];
  logic [31:0]          prev_r, prev_nxt;
  logic [31:0]          cur_r, cur_nxt;
  logic [31:0]          prod_r;
  logic [31:0]          kbuf_r [MAX_KEY_WORDS];
  logic                 kbuf_we;
  logic [31:0]          oq_r [2];
  logic                 oq_wp_r, oq_rp_r;
  logic [1:0]           oq_cnt_r;
  logic                 oq_push, oq_pop, oq_full;

  logic [31:0] mul_a, mul_b;
  logic [31:0] mul_full;

  logic              ram_we, ra_en, rb_en;
  logic [ADDR_W-1:0] ram_waddr, ra_addr, rb_addr;
  logic [31:0]       ram_wdata, ra_data, rb_data;

  logic [IDX_W-1:0]     n_next_word, n_far_word, head_idx;
  logic [KEY_CNT_W-1:0] j_plus;
  logic [31:0]          k1_val, k2_val;

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(INSTANCES * STATE_WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_en   (ra_en),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_en   (rb_en),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  assign mul_a    = prev_r ^ (prev_r >> 30);
  assign mul_full = mul_a * mul_b;

  assign n_next_word = (n_r == LAST_WORD) ? '0 : n_r + 1'b1;
  assign n_far_word  = (n_r < FAR_SPLIT) ? n_r + IDX_W'(SHIFT_M) : n_r - FAR_SPLIT;
  assign head_idx    = idx_r[cmd.inst];
  assign j_plus      = KEY_CNT_W'(j_r) + 1'b1;
  assign k1_val      = (ra_data ^ prod_r) + kbuf_r[j_r] + 32'(j_r);
  assign k2_val      = (ra_data ^ prod_r) - 32'(n_r);

  assign oq_full         = (oq_cnt_r == 2'd2);
  assign out_empty       = (oq_cnt_r == 2'd0);
  assign out_random_word = oq_r[oq_rp_r];
  assign oq_pop          = out_pop && !out_empty;
  assign oq_push         = (state_r == ST_GEN_OUT) && !oq_full;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    inst_nxt  = inst_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    len_nxt   = len_r;
    kcnt_nxt  = kcnt_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    kbuf_we   = 1'b0;
    cmd_pop   = 1'b0;
    mul_b     = SEED_MULT;
    ram_we    = 1'b0;
    ram_waddr = word_addr(inst_r, n_r);
    ram_wdata = 32'd0;
    ra_en     = 1'b0;
    ra_addr   = word_addr(inst_r, n_r);
    rb_en     = 1'b0;
    rb_addr   = word_addr(inst_r, n_far_word);

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          inst_nxt = cmd.inst;
          n_nxt    = IDX_W'(1);
          unique case (cmd.opcode)
            OP_SEED: begin
              ram_we    = 1'b1;
              ram_waddr = word_addr(cmd.inst, '0);
              ram_wdata = cmd.value;
              prev_nxt  = cmd.value;
              mode_nxt  = MODE_SEED;
              idx_nxt[cmd.inst] = IDX_SPENT;
              state_nxt = ST_SEED_MUL;
            end
            OP_KEY: begin
              if (kcnt_r < KEY_CNT_W'(MAX_KEY_WORDS)) begin
                kbuf_we  = 1'b1;
                kcnt_nxt = kcnt_r + 1'b1;
              end
              if (cmd.key_last) begin
                len_nxt   = (kcnt_nxt == '0) ? KEY_CNT_W'(1) : kcnt_nxt;
                kcnt_nxt  = '0;
                ram_we    = 1'b1;
                ram_waddr = word_addr(cmd.inst, '0);
                ram_wdata = KEY_SEED;
                prev_nxt  = KEY_SEED;
                mode_nxt  = MODE_KEY;
                idx_nxt[cmd.inst] = IDX_SPENT;
                state_nxt = ST_SEED_MUL;
              end
            end
            OP_GEN: begin
              mode_nxt = MODE_GEN;
              if (head_idx == IDX_UNSEEDED) begin
                ram_we    = 1'b1;
                ram_waddr = word_addr(cmd.inst, '0);
                ram_wdata = DEFAULT_SEED;
                prev_nxt  = DEFAULT_SEED;
                state_nxt = ST_SEED_MUL;
              end else if (head_idx >= IDX_SPENT) begin
                state_nxt = ST_TW_RD0;
              end else begin
                state_nxt = ST_GEN_RD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEED_MUL: begin
        mul_b     = SEED_MULT;
        state_nxt = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        ram_we    = 1'b1;
        ram_wdata = prod_r + 32'(n_r);
        prev_nxt  = ram_wdata;
        n_nxt     = n_r + 1'b1;
        state_nxt = ST_SEED_MUL;
        if (n_r == LAST_WORD) begin
          unique case (mode_r)
            MODE_KEY: begin
              n_nxt     = IDX_W'(1);
              j_nxt     = '0;
              k_nxt     = KEY_ROUNDS1;
              prev_nxt  = KEY_SEED;
              state_nxt = ST_K1_RD;
            end
            MODE_GEN: begin
              state_nxt = ST_TW_RD0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_K1_RD: begin
        ra_en     = 1'b1;
        mul_b     = KEY_MULT1;
        state_nxt = ST_K1_WR;
      end
      ST_K1_WR: begin
        ram_we    = 1'b1;
        ram_wdata = k1_val;
        prev_nxt  = k1_val;
        n_nxt     = n_r + 1'b1;
        j_nxt     = (j_plus >= len_r) ? '0 : KEY_IDX_W'(j_plus);
        k_nxt     = k_r - 1'b1;
        if (n_r == LAST_WORD) begin
          state_nxt = ST_K1_WRAP;
        end else if (k_r == IDX_W'(1)) begin
          k_nxt     = KEY_ROUNDS2;
          state_nxt = ST_K2_RD;
        end else begin
          state_nxt = ST_K1_RD;
        end
      end
      ST_K1_WRAP: begin
        // Word zero takes a copy of the last word whenever the walk wraps.
        ram_we    = 1'b1;
        ram_waddr = word_addr(inst_r, '0);
        ram_wdata = prev_r;
        n_nxt     = IDX_W'(1);
        if (k_r == '0) begin
          k_nxt     = KEY_ROUNDS2;
          state_nxt = ST_K2_RD;
        end else begin
          state_nxt = ST_K1_RD;
        end
      end
      ST_K2_RD: begin
        ra_en     = 1'b1;
        mul_b     = KEY_MULT2;
        state_nxt = ST_K2_WR;
      end
      ST_K2_WR: begin
        ram_we    = 1'b1;
        ram_wdata = k2_val;
        prev_nxt  = k2_val;
        n_nxt     = n_r + 1'b1;
        k_nxt     = k_r - 1'b1;
        if (n_r == LAST_WORD) begin
          state_nxt = ST_K2_WRAP;
        end else if (k_r == IDX_W'(1)) begin
          state_nxt = ST_K_FIN;
        end else begin
          state_nxt = ST_K2_RD;
        end
      end
      ST_K2_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = word_addr(inst_r, '0);
        ram_wdata = prev_r;
        n_nxt     = IDX_W'(1);
        state_nxt = (k_r == '0) ? ST_K_FIN : ST_K2_RD;
      end
      ST_K_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = word_addr(inst_r, '0);
        ram_wdata = HI_BIT;
        state_nxt = ST_IDLE;
      end
      ST_TW_RD0: begin
        ra_en     = 1'b1;
        ra_addr   = word_addr(inst_r, '0);
        n_nxt     = '0;
        state_nxt = ST_TW_LD;
      end
      ST_TW_LD: begin
        cur_nxt   = ra_data;
        state_nxt = ST_TW_RD;
      end
      ST_TW_RD: begin
        ra_en     = 1'b1;
        ra_addr   = word_addr(inst_r, n_next_word);
        rb_en     = 1'b1;
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = twist_one(cur_r, ra_data, rb_data);
        cur_nxt   = ra_data;
        n_nxt     = n_r + 1'b1;
        if (n_r == LAST_WORD) begin
          idx_nxt[inst_r] = '0;
          state_nxt       = ST_GEN_RD;
        end else begin
          state_nxt = ST_TW_RD;
        end
      end
      ST_GEN_RD: begin
        ra_en     = 1'b1;
        ra_addr   = word_addr(inst_r, idx_r[inst_r]);
        state_nxt = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        if (!oq_full) begin
          idx_nxt[inst_r] = idx_r[inst_r] + 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= MODE_SEED;
      kcnt_r   <= '0;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
      for (int i = 0; i < INSTANCES; i++) begin
        idx_r[i] <= IDX_UNSEEDED;
      end
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      kcnt_r  <= kcnt_nxt;
      idx_r   <= idx_nxt;
      if (oq_push) begin
        oq_wp_r <= ~oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= ~oq_rp_r;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inst_r <= inst_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    len_r  <= len_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    prod_r <= mul_full;
    if (kbuf_we) begin
      kbuf_r[kcnt_r[KEY_IDX_W-1:0]] <= cmd.value;
    end
    if (oq_push) begin
      oq_r[oq_wp_r] <= temper(ra_data);
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE && !cmd_empty))
    else $error("command taken while busy");

  a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TW_WR && n_r == LAST_WORD) |=> (state_r == ST_GEN_RD))
    else $error("twist did not hand over to the read");

  a_gen_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_RD) |-> (idx_r[inst_r] < IDX_SPENT))
    else $error("read index spent at word read");

endmodule
